[rtl/core/tvsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvsv_pkg: shared types and codes of the tagged value stream validator
// Event, role, status and tag codes, header constants, and the result record that leaves the front.
// ----------------------------------------------------------------------------
package tvsv_pkg;

  localparam logic [3:0] EV_HEADER    = 4'd0;
  localparam logic [3:0] EV_NUM_TAG   = 4'd1;
  localparam logic [3:0] EV_NUM_BYTE  = 4'd2;
  localparam logic [3:0] EV_BOOL_TAG  = 4'd3;
  localparam logic [3:0] EV_BOOL      = 4'd4;
  localparam logic [3:0] EV_STR_TAG   = 4'd5;
  localparam logic [3:0] EV_LEN_BYTE  = 4'd6;
  localparam logic [3:0] EV_STR_BYTE  = 4'd7;
  localparam logic [3:0] EV_TABLE_TAG = 4'd8;
  localparam logic [3:0] EV_COUNT     = 4'd9;
  localparam logic [3:0] EV_IGNORED   = 4'd10;

  localparam logic [1:0] ROLE_TOP = 2'd0;
  localparam logic [1:0] ROLE_KEY = 2'd1;
  localparam logic [1:0] ROLE_VAL = 2'd2;

  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_CORRUPT   = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
  localparam logic [2:0] ST_BAD_VER   = 3'd4;
  localparam logic [2:0] ST_BAD_WIDTH = 3'd5;
  localparam logic [2:0] ST_TRAILING  = 3'd6;

  localparam logic [7:0] TAG_NUM   = 8'h01;
  localparam logic [7:0] TAG_STR   = 8'h02;
  localparam logic [7:0] TAG_BOOL  = 8'h03;
  localparam logic [7:0] TAG_TABLE = 8'h04;

  localparam logic [7:0] MAGIC_0 = 8'h4B;
  localparam logic [7:0] MAGIC_1 = 8'h53;
  localparam logic [7:0] VERSION = 8'h01;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] data;
    logic [8:0] nesting_level;
    logic [1:0] role;
    logic       value_end;
    logic [8:0] tables_closed;
    logic [2:0] status;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/tvsv_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvsv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module tvsv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/tvsv_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvsv_front: byte parser of the validator
// Classifies each accepted byte against the wire format and keeps the
// table stack, whose top level lives in registers and the rest in a RAM.
// ----------------------------------------------------------------------------
module tvsv_front #(
  parameter int MaxDepth    = 256,
  parameter int NumberBytes = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output tvsv_pkg::result_t     result_o
);
  import tvsv_pkg::*;

  localparam int Aw = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  typedef enum logic [3:0] {
    PH_HEADER, PH_TAG, PH_NUM, PH_BOOL, PH_STRLEN, PH_STRBODY, PH_COUNT,
    PH_DONE, PH_ERROR
  } phase_e;

  typedef struct packed {
    logic [32:0] left;
    logic [8:0]  target;
  } level_t;

  phase_e      phase_q, phase_d;
  logic [23:0] hdr_q, hdr_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [31:0] acc_q, acc_d, acc_n;
  logic [31:0] sleft_q, sleft_d;
  logic [8:0]  depth_q, depth_d, tgt;
  logic        done_q, done_d;
  logic [32:0] left_q, left_d, cur_left;
  logic [8:0]  ltgt_q, ltgt_d, cur_tgt;
  logic        from_ram_q, from_ram_d;
  logic        fin, extra;
  logic [2:0]  flag;
  logic        ram_we, ram_re;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  level_t      ram_wdata, ram_rdata;
  result_t     res;

  tvsv_ram #(.Width($bits(level_t)), .Depth(MaxDepth)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Right after a pop the new top level is the RAM read data.
  assign cur_left = from_ram_q ? ram_rdata.left : left_q;
  assign cur_tgt  = from_ram_q ? ram_rdata.target : ltgt_q;

  always_comb begin
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    fbc_d      = fbc_q;
    acc_d      = acc_q;
    acc_n      = acc_q;
    sleft_d    = sleft_q;
    depth_d    = depth_q;
    done_d     = done_q;
    left_d     = cur_left;
    ltgt_d     = cur_tgt;
    from_ram_d = 1'b0;
    tgt        = 9'd0;
    fin        = 1'b0;
    extra      = 1'b0;
    flag       = ST_BUSY;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = Aw'(depth_q - 9'd1);
    ram_raddr  = '0;
    ram_wdata  = '{left: cur_left, target: cur_tgt};
    res        = '0;
    res.event_res = EV_IGNORED;
    res.data      = data_byte_i;

    case (phase_q)
      PH_HEADER: begin
        res.event_res = EV_HEADER;
        if (fbc_q < 3'd3) begin
          hdr_d[8*fbc_q[1:0] +: 8] = data_byte_i;
          fbc_d = fbc_q + 3'd1;
        end else begin
          fbc_d = 3'd0;
          if (hdr_q[7:0] != MAGIC_0 || hdr_q[15:8] != MAGIC_1) begin
            flag = ST_BAD_MAGIC;
          end else if (hdr_q[23:16] != VERSION) begin
            flag = ST_BAD_VER;
          end else if (data_byte_i != 8'(NumberBytes)) begin
            flag = ST_BAD_WIDTH;
          end else begin
            phase_d = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        if (depth_q >= 9'(MaxDepth)) begin
          flag = ST_CORRUPT;
        end else begin
          fbc_d = 3'd0;
          acc_d = 32'd0;
          case (data_byte_i)
            TAG_NUM: begin
              res.event_res = EV_NUM_TAG;
              phase_d = PH_NUM;
            end
            TAG_STR: begin
              res.event_res = EV_STR_TAG;
              phase_d = PH_STRLEN;
            end
            TAG_BOOL: begin
              res.event_res = EV_BOOL_TAG;
              phase_d = PH_BOOL;
            end
            TAG_TABLE: begin
              res.event_res = EV_TABLE_TAG;
              phase_d = PH_COUNT;
            end
            default: flag = ST_CORRUPT;
          endcase
          if (flag == ST_BUSY) begin
            if (depth_q != 9'd0 && cur_left != 33'd0) begin
              left_d = cur_left - 33'd1;
            end
            res.nesting_level = depth_q;
            res.role = (depth_q == 9'd0) ? ROLE_TOP : (left_d[0] ? ROLE_KEY : ROLE_VAL);
          end
        end
      end
      PH_NUM: begin
        res.event_res = EV_NUM_BYTE;
        if (({1'b0, fbc_q} + 4'd1) >= 4'(NumberBytes)) begin
          fbc_d = 3'd0;
          fin   = 1'b1;
        end else begin
          fbc_d = fbc_q + 3'd1;
        end
      end
      PH_BOOL: begin
        res.event_res = EV_BOOL;
        res.data = {7'd0, |data_byte_i};
        fin = 1'b1;
      end
      PH_STRLEN, PH_COUNT: begin
        res.event_res = (phase_q == PH_STRLEN) ? EV_LEN_BYTE : EV_COUNT;
        acc_n[8*fbc_q[1:0] +: 8] = acc_q[8*fbc_q[1:0] +: 8] | data_byte_i;
        acc_d = acc_n;
        if (fbc_q < 3'd3) begin
          fbc_d = fbc_q + 3'd1;
        end else begin
          fbc_d = 3'd0;
          if (acc_n == 32'd0) begin
            fin   = 1'b1;
            extra = (phase_q == PH_COUNT);
          end else if (phase_q == PH_STRLEN) begin
            sleft_d = acc_n;
            phase_d = PH_STRBODY;
          end else if (depth_q < 9'(MaxDepth)) begin
            // Open a table: save the enclosing level and work out where
            // unwinding stops once this table completes.
            ram_we = (depth_q != 9'd0);
            ltgt_d = (depth_q == 9'd0) ? 9'd0 :
                     ((cur_left == 33'd0) ? cur_tgt : depth_q);
            left_d  = {acc_n, 1'b0};
            depth_d = depth_q + 9'd1;
            phase_d = PH_TAG;
          end
        end
      end
      PH_STRBODY: begin
        res.event_res = EV_STR_BYTE;
        sleft_d = (sleft_q != 32'd0) ? sleft_q - 32'd1 : 32'd0;
        fin = (sleft_d == 32'd0);
      end
      PH_DONE: flag = ST_TRAILING;
      default: ;
    endcase

    if (phase_q != PH_HEADER && phase_q != PH_TAG && phase_q != PH_DONE &&
        phase_q != PH_ERROR) begin
      res.nesting_level = depth_q;
      res.role = (depth_q == 9'd0) ? ROLE_TOP : (cur_left[0] ? ROLE_KEY : ROLE_VAL);
    end

    if (fin) begin
      res.value_end = 1'b1;
      if (depth_q != 9'd0 && cur_left != 33'd0) begin
        phase_d = PH_TAG;
      end else begin
        if (depth_q != 9'd0) begin
          tgt = (cur_tgt > depth_q) ? 9'd0 : cur_tgt;
          res.tables_closed = depth_q - tgt;
          depth_d = tgt;
          if (tgt != 9'd0) begin
            ram_re     = 1'b1;
            ram_raddr  = Aw'(tgt - 9'd1);
            from_ram_d = 1'b1;
          end
        end
        if (depth_d == 9'd0) begin
          done_d  = 1'b1;
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_TAG;
        end
      end
      res.tables_closed = res.tables_closed + {8'd0, extra};
    end

    if (flag != ST_BUSY) begin
      phase_d    = PH_ERROR;
      res.status = flag;
    end else if (last_byte_i && phase_q != PH_ERROR) begin
      res.status = done_d ? ST_ACCEPTED : ST_CORRUPT;
    end

    if (last_byte_i) begin
      phase_d    = PH_HEADER;
      hdr_d      = 24'd0;
      fbc_d      = 3'd0;
      acc_d      = 32'd0;
      sleft_d    = 32'd0;
      depth_d    = 9'd0;
      done_d     = 1'b0;
      from_ram_d = 1'b0;
    end

    ram_we = ram_we & accept_i;
    ram_re = ram_re & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_q      <= 24'd0;
      fbc_q      <= 3'd0;
      acc_q      <= 32'd0;
      sleft_q    <= 32'd0;
      depth_q    <= 9'd0;
      done_q     <= 1'b0;
      from_ram_q <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      hdr_q      <= hdr_d;
      fbc_q      <= fbc_d;
      acc_q      <= acc_d;
      sleft_q    <= sleft_d;
      depth_q    <= depth_d;
      done_q     <= done_d;
      from_ram_q <= from_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      left_q <= left_d;
      ltgt_q <= ltgt_d;
    end
  end

  assign result_o = res;

endmodule
`default_nettype wire

[rtl/core/tvsv_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvsv_queue: two-entry result queue
// Holds parsed results until the consumer pops them; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module tvsv_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire tvsv_pkg::result_t wdata_i,
  output logic                   full_o,
  input  wire logic              rd_i,
  output logic                   empty_o,
  output tvsv_pkg::result_t      rdata_o
);
  import tvsv_pkg::*;

  result_t    slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule
`default_nettype wire

[rtl/core/tagged_value_stream_validator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Latency: a byte's result is ready to pop in the cycle after its push.
// Throughput: one byte per cycle unless the queue is full, set by the parser
// step and the one-write, one-read stack RAM (a pop's read lands in time for
// the next byte). The two-entry result queue lets the consumer stall alone.
// Reset: asynchronous, active low; clears the parser and the queue. The
// stack RAM needs no clearing, since each entry is written before use.
// ----------------------------------------------------------------------------
// tagged_value_stream_validator: streaming checker of a tagged wire format
// Takes one byte per transaction and returns one result per byte that
// names the token, its nesting level and role, and the buffer status.
// ----------------------------------------------------------------------------
module tagged_value_stream_validator #(
  parameter int MAX_DEPTH    = 256,
  parameter int NUMBER_BYTES = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      event_res_o,
  output logic [7:0]      data_o,
  output logic [8:0]      nesting_level_o,
  output logic [1:0]      role_o,
  output logic            value_end_o,
  output logic [8:0]      tables_closed_o,
  output logic [2:0]      status_o
);
  import tvsv_pkg::*;

  result_t front_res, back_res;
  logic    accept;

  // A byte transaction is taken whenever the queue has room for its result.
  assign accept = push & ~full;

  tvsv_front #(.MaxDepth(MAX_DEPTH), .NumberBytes(NUMBER_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .result_o    (front_res)
  );

  // The queue decouples the parser from the consumer of results.
  tvsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_res),
    .full_o  (full),
    .rd_i    (pop),
    .empty_o (empty),
    .rdata_o (back_res)
  );

  assign event_res_o     = back_res.event_res;
  assign data_o          = back_res.data;
  assign nesting_level_o = back_res.nesting_level;
  assign role_o          = back_res.role;
  assign value_end_o     = back_res.value_end;
  assign tables_closed_o = back_res.tables_closed;
  assign status_o        = back_res.status;

endmodule
`default_nettype wire

[tb/tagged_value_stream_validator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_value_stream_validator_tb: self-checking bench of the stream validator
// Feeds whole buffers (well-formed, truncated, corrupt, over-long and deeply
// nested ones) byte by byte, predicts each result and compares it field by
// field with what the block returns, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tagged_value_stream_validator_tb;
  import tvsv_pkg::*;

  localparam int NUM_BYTES   = 4;
  localparam int MAX_LEVELS  = 256;
  localparam int DEEP_LEVELS = 40;
  localparam int STALL_PCT   = 34;
  localparam int WDOG_LIMIT  = 5000;
  localparam int ITEM_TARGET = 600;

  // Parser phases of the predictor.
  typedef enum int {
    PH_HEADER, PH_TAG, PH_NUM, PH_BOOL, PH_STRLEN, PH_STRBODY, PH_COUNT, PH_DONE,
    PH_ERROR
  } phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [7:0] data_byte_i = '0;
  logic last_byte_i = 1'b0;
  logic full, empty;
  logic [3:0] event_res_o;
  logic [7:0] data_o;
  logic [8:0] nesting_level_o;
  logic [1:0] role_o;
  logic value_end_o;
  logic [8:0] tables_closed_o;
  logic [2:0] status_o;

  tagged_value_stream_validator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .data_byte_i(data_byte_i), .last_byte_i(last_byte_i),
    .empty(empty), .pop(pop),
    .event_res_o(event_res_o), .data_o(data_o), .nesting_level_o(nesting_level_o),
    .role_o(role_o), .value_end_o(value_end_o), .tables_closed_o(tables_closed_o),
    .status_o(status_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  byte_item_t  byte_stream[$];    // bytes still to be offered to the block
  result_t     expected_tokens[$]; // predicted results in arrival order
  logic [7:0]  frame[$];           // buffer under construction
  int unsigned cycle_no = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the parser, kept in step with accepted bytes.
  // ---------------------------------------------------------------------------
  logic [23:0] hdr_bytes;
  phase_e      phase;
  int unsigned field_cnt;
  logic [31:0] len_acc;
  logic [31:0] str_left;
  logic [32:0] items_left[MAX_LEVELS];
  logic [8:0]  unwind_to[MAX_LEVELS];
  int unsigned depth;
  bit          top_done;

  function automatic void clear_parser();
    hdr_bytes = '0;
    phase = PH_HEADER;
    field_cnt = 0;
    len_acc = '0;
    str_left = '0;
    depth = 0;
    top_done = 1'b0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      items_left[k] = '0;
      unwind_to[k] = '0;
    end
  endfunction

  // Keys sit at odd remaining counts: the key of a pair starts before its value.
  function automatic logic [1:0] role_here();
    if (depth == 0 || depth > MAX_LEVELS) return ROLE_TOP;
    return items_left[depth-1][0] ? ROLE_KEY : ROLE_VAL;
  endfunction

  function automatic void open_item();
    if (depth > 0 && depth <= MAX_LEVELS && items_left[depth-1] != 0)
      items_left[depth-1] = items_left[depth-1] - 1;
  endfunction

  // A value has ended at the current depth; unwinds every table it completes.
  function automatic int unsigned close_item();
    int unsigned shut;
    int unsigned tgt;
    shut = 0;
    if (depth > 0 && depth <= MAX_LEVELS) begin
      if (items_left[depth-1] != 0) begin
        phase = PH_TAG;
        return 0;
      end
      tgt = unwind_to[depth-1];
      if (tgt > depth) tgt = 0;
      shut = depth - tgt;
      depth = tgt;
    end
    if (depth == 0) begin
      top_done = 1'b1;
      phase = PH_DONE;
    end else begin
      phase = PH_TAG;
    end
    return shut;
  endfunction

  // The unwind target lets one byte close a whole chain of final-entry tables.
  function automatic void open_table(logic [31:0] pairs);
    int unsigned d;
    d = depth;
    if (d >= MAX_LEVELS) return;
    items_left[d] = {1'b0, pairs} << 1;
    if (d == 0) unwind_to[d] = '0;
    else if (items_left[d-1] == 0) unwind_to[d] = unwind_to[d-1];
    else unwind_to[d] = 9'(d);
    depth = d + 1;
    phase = PH_TAG;
  endfunction

  function automatic result_t predict_token(logic [7:0] b, logic last);
    result_t r;
    logic [2:0] flag;
    bit was_err;
    bit is_str;
    int unsigned shut;
    r = '0;
    r.event_res = EV_IGNORED;
    r.data = b;
    flag = ST_BUSY;
    shut = 0;
    was_err = (phase == PH_ERROR);
    case (phase)
      PH_HEADER: begin
        r.event_res = EV_HEADER;
        if (field_cnt < 3) begin
          hdr_bytes = hdr_bytes | (24'(b) << (8 * field_cnt));
          field_cnt++;
        end else begin
          field_cnt = 0;
          if (hdr_bytes[7:0] != MAGIC_0 || hdr_bytes[15:8] != MAGIC_1) flag = ST_BAD_MAGIC;
          else if (hdr_bytes[23:16] != VERSION) flag = ST_BAD_VER;
          else if (b != 8'(NUM_BYTES)) flag = ST_BAD_WIDTH;
          else phase = PH_TAG;
        end
      end
      PH_TAG: begin
        if (depth >= MAX_LEVELS) begin
          flag = ST_CORRUPT;
        end else begin
          field_cnt = 0;
          len_acc = '0;
          case (b)
            TAG_NUM:   begin r.event_res = EV_NUM_TAG;   phase = PH_NUM;    end
            TAG_STR:   begin r.event_res = EV_STR_TAG;   phase = PH_STRLEN; end
            TAG_BOOL:  begin r.event_res = EV_BOOL_TAG;  phase = PH_BOOL;   end
            TAG_TABLE: begin r.event_res = EV_TABLE_TAG; phase = PH_COUNT;  end
            default:   flag = ST_CORRUPT;
          endcase
          if (flag == ST_BUSY) begin
            open_item();
            r.nesting_level = 9'(depth);
            r.role = role_here();
          end
        end
      end
      PH_NUM: begin
        r.event_res = EV_NUM_BYTE;
        r.nesting_level = 9'(depth);
        r.role = role_here();
        if (field_cnt + 1 >= NUM_BYTES) begin
          field_cnt = 0;
          r.value_end = 1'b1;
          shut = close_item();
        end else begin
          field_cnt++;
        end
      end
      PH_BOOL: begin
        r.event_res = EV_BOOL;
        r.data = (b != 0) ? 8'd1 : 8'd0;
        r.nesting_level = 9'(depth);
        r.role = role_here();
        r.value_end = 1'b1;
        shut = close_item();
      end
      PH_STRLEN, PH_COUNT: begin
        is_str = (phase == PH_STRLEN);
        r.event_res = is_str ? EV_LEN_BYTE : EV_COUNT;
        r.nesting_level = 9'(depth);
        r.role = role_here();
        len_acc = len_acc | (32'(b) << (8 * (field_cnt & 3)));
        if (field_cnt < 3) begin
          field_cnt++;
        end else begin
          field_cnt = 0;
          if (len_acc == 0) begin
            // An empty table counts itself as closed.
            r.value_end = 1'b1;
            shut = close_item() + (is_str ? 0 : 1);
          end else if (is_str) begin
            str_left = len_acc;
            phase = PH_STRBODY;
          end else begin
            open_table(len_acc);
          end
        end
      end
      PH_STRBODY: begin
        r.event_res = EV_STR_BYTE;
        r.nesting_level = 9'(depth);
        r.role = role_here();
        if (str_left != 0) str_left--;
        if (str_left == 0) begin
          r.value_end = 1'b1;
          shut = close_item();
        end
      end
      PH_DONE: flag = ST_TRAILING;
      default: ;
    endcase
    r.tables_closed = 9'(shut);
    if (flag != ST_BUSY) begin
      phase = PH_ERROR;
      r.status = flag;
    end else if (last && !was_err) begin
      r.status = top_done ? ST_ACCEPTED : ST_CORRUPT;
    end
    if (last) clear_parser();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Buffer construction.
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    frame = {frame, b};
  endfunction

  // Keeps only the first bytes of the frame.
  function automatic void trim_frame(int keep);
    if (keep > 0 && frame.size() > keep) frame = frame[0:keep-1];
  endfunction

  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endfunction

  function automatic void put_header();
    add_byte(MAGIC_0);
    add_byte(MAGIC_1);
    add_byte(VERSION);
    add_byte(8'(NUM_BYTES));
  endfunction

  // Emits one random value; tables appear only at levels below three so buffers stay short.
  function automatic void put_value(int lvl);
    int kind;
    int n;
    kind = $urandom_range(lvl < 3 ? 4 : 3, 1);
    case (kind)
      1: begin
        add_byte(TAG_NUM);
        for (int i = 0; i < NUM_BYTES; i++) add_byte(8'($urandom));
      end
      2: begin
        add_byte(TAG_BOOL);
        case ($urandom_range(2))
          0: add_byte(8'h00);
          1: add_byte(8'h01);
          default: add_byte(8'($urandom));
        endcase
      end
      3: begin
        n = $urandom_range(6);
        add_byte(TAG_STR);
        put_word(32'(n));
        for (int i = 0; i < n; i++) add_byte(8'($urandom));
      end
      default: begin
        n = $urandom_range(3);
        add_byte(TAG_TABLE);
        put_word(32'(n));
        for (int i = 0; i < 2 * n; i++) put_value(lvl + 1);
      end
    endcase
  endfunction

  // Moves the frame into the byte stream, the final byte marked as last.
  function automatic void ship_frame();
    byte_item_t it;
    for (int i = 0; i < frame.size(); i++) begin
      it.b = frame[i];
      it.last = (i == frame.size() - 1);
      byte_stream = {byte_stream, it};
    end
    frame.delete();
  endfunction

  function automatic void random_frame();
    int pick;
    int cut;
    pick = $urandom_range(99);
    put_header();
    if (pick < 5) begin
      // Corrupt one header byte, then stop inside the header or go on with a value.
      cut = $urandom_range(3);
      frame[cut] = frame[cut] ^ 8'(1 << $urandom_range(7));
      if ($urandom_range(1)) trim_frame($urandom_range(3, 1));
      else put_value(0);
    end else if (pick < 12) begin
      // Unknown tag somewhere a tag is due.
      add_byte(TAG_TABLE);
      put_word(32'd1);
      put_value(1);
      add_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 5)));
      for (int i = $urandom_range(2); i > 0; i--) add_byte(8'($urandom));
    end else begin
      put_value(0);
      if (pick < 22) begin
        cut = $urandom_range(frame.size() - 1, 1);
        trim_frame(cut);
      end else if (pick < 30) begin
        for (int i = $urandom_range(3, 1); i > 0; i--) add_byte(8'($urandom));
      end
    end
    ship_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers the next byte, holding it until the block takes it.
  // ---------------------------------------------------------------------------
  function automatic bit idle_now();
    if (cycle_no > 3000 && cycle_no < 4500) return 1'b0;
    return $urandom_range(99) < STALL_PCT;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      cycle_no <= cycle_no + 1;
      if (push && !full) begin
        expected_tokens = {expected_tokens, predict_token(data_byte_i, last_byte_i)};
        void'(byte_stream.pop_front());
      end
      if (!push || !full) begin
        if (byte_stream.size() > 0 && !idle_now()) begin
          push <= 1'b1;
          data_byte_i <= byte_stream[0].b;
          last_byte_i <= byte_stream[0].last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pops at random, with one long hold-off so the block fills and
  // pushes back on the sender. Each accepted transaction is checked.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          held = 1'b0;

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_tokens.size() == 0) begin
          $error("result with no byte pending");
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("event_res", want.event_res, event_res_o);
          check_field("data", want.data, data_o);
          check_field("nesting_level", want.nesting_level, nesting_level_o);
          check_field("role", want.role, role_o);
          check_field("value_end", want.value_end, value_end_o);
          check_field("tables_closed", want.tables_closed, tables_closed_o);
          check_field("status", want.status, status_o);
        end
      end
      if (!held && results_seen >= 250) begin
        held <= 1'b1;
        hold_left <= 300;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= !idle_now();
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either side.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed buffers first, then random ones, all queued up front.
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();
    // One of each value kind, including extremes of the bool and empty bodies.
    put_header(); add_byte(TAG_NUM); put_word(32'hFFFF_FFFF); ship_frame();
    put_header(); add_byte(TAG_BOOL); add_byte(8'hFF); ship_frame();
    put_header(); add_byte(TAG_BOOL); add_byte(8'h00); ship_frame();
    put_header(); add_byte(TAG_STR); put_word(32'd0); ship_frame();
    put_header(); add_byte(TAG_STR); put_word(32'd2);
    add_byte(8'h00); add_byte(8'hFF); ship_frame();
    put_header(); add_byte(TAG_TABLE); put_word(32'd0); ship_frame();
    // Nested final entries close several tables on one byte.
    put_header(); add_byte(TAG_TABLE); put_word(32'd1);
    add_byte(TAG_BOOL); add_byte(8'h01);
    add_byte(TAG_TABLE); put_word(32'd1);
    add_byte(TAG_NUM); put_word(32'h0102_0304);
    add_byte(TAG_TABLE); put_word(32'd0); ship_frame();
    // Header errors in priority order, then a short header.
    add_byte(8'h00); add_byte(MAGIC_1); add_byte(8'h07);
    add_byte(8'h09); add_byte(TAG_NUM); ship_frame();
    add_byte(MAGIC_0); add_byte(MAGIC_1); add_byte(8'h02);
    add_byte(8'(NUM_BYTES)); ship_frame();
    add_byte(MAGIC_0); add_byte(MAGIC_1); add_byte(VERSION);
    add_byte(8'h08); ship_frame();
    add_byte(MAGIC_0); add_byte(MAGIC_1); ship_frame();
    // Unknown tag, trailing bytes, truncation with a huge count.
    put_header(); add_byte(8'hFF); add_byte(TAG_NUM); ship_frame();
    put_header(); add_byte(TAG_BOOL); add_byte(8'h01);
    add_byte(8'hAA); add_byte(8'h55); ship_frame();
    put_header(); add_byte(TAG_TABLE); put_word(32'hFFFF_FFFF);
    add_byte(TAG_STR); put_word(32'hFFFF_FFFF); add_byte(8'h5A); ship_frame();
    // A deep chain of single-pair tables that one byte unwinds completely.
    put_header();
    for (int i = 0; i < DEEP_LEVELS; i++) begin
      add_byte(TAG_TABLE); put_word(32'd1);
    end
    add_byte(TAG_BOOL); add_byte(8'h01); add_byte(TAG_TABLE);
    put_word(32'd0); ship_frame();

    while (byte_stream.size() < ITEM_TARGET) random_frame();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (byte_stream.size() == 0 && expected_tokens.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
